>>> rtl/tiled_matrix_multiply_top_assert.svh
// Assertion shorthands for the tile multiply engine.
// Both sample on the rising edge of aclk and are off while aresetn is low.
`ifndef TILED_MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define TILED_MATRIX_MULTIPLY_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TMM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tmm_pkg.sv
`timescale 1ns / 1ps

package tmm_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int INDEX_W   = 8;
    localparam int DIM_CFG_W = 5;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 32;
    localparam int DIM_RESET = 16;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic load;     // seed the running sum with the stored accumulator
        logic mul_en;   // tile operands are valid this cycle
    } tmm_mac_ctrl_t;

endpackage

>>> rtl/tmm_ram.sv
`timescale 1ns / 1ps

module tmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/tmm_mac.sv
`timescale 1ns / 1ps

module tmm_mac (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tmm_pkg::tmm_mac_ctrl_t       ctrl,
    input  logic [tmm_pkg::DATA_W-1:0]   init,
    input  logic [tmm_pkg::DATA_W-1:0]   a_data,
    input  logic [tmm_pkg::DATA_W-1:0]   b_data,
    output logic [tmm_pkg::DATA_W-1:0]   sum,
    output logic                         pending
);

    import tmm_pkg::*;

    logic [DATA_W-1:0] product_reg;
    logic              prod_valid_reg;
    logic [DATA_W-1:0] sum_reg;
    logic [DATA_W-1:0] product_next;

    // Low word of the product; the wrap makes signedness irrelevant.
    assign product_next = a_data * b_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= ctrl.mul_en;
        end
        if (ctrl.mul_en) begin
            product_reg <= product_next;
        end
        if (ctrl.load) begin
            sum_reg <= init;
        end else if (prod_valid_reg) begin
            sum_reg <= sum_reg + product_reg;
        end
    end

    assign sum     = sum_reg;
    assign pending = prod_valid_reg;

endmodule

>>> rtl/tiled_matrix_multiply_top.sv
`timescale 1ns / 1ps
// Tile matrix-multiply engine with one shared 32x32 multiply-accumulate unit.
// Each input transfer carries an op in s_tuser: load writes one A and one B
// element at the row-major index (nothing is written when the index lies
// outside the tile), read returns the accumulator at that index (zero when
// outside the tile), clear zeroes every accumulator. A load with s_tlast high
// adds A*B of the current tiles into the accumulators, wrapping modulo 2^32.
// A read waits while the output register still holds a result that m_tready
// has not taken. The same clearing sweep runs after reset, so s_tready rises
// only once every accumulator is zeroed. The accumulation time is set by the
// single MAC unit and the one read port of each tile memory: one product per
// cycle, with an accumulator fetch before the products and a drain and a
// write-back after them for each accumulator. A finished read result sits in
// the output register while the next transfer is taken. Configure tile_dim
// only while the engine is idle; 0 acts as 1 and values above MAX_TILE as
// MAX_TILE.

`include "tiled_matrix_multiply_top_assert.svh"

module tiled_matrix_multiply_top #(
    parameter int MAX_TILE = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration: tile_dim
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tmm_pkg::DIM_CFG_W-1:0]     cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tmm_pkg::S_TDATA_W-1:0]     s_tdata,  // index[7:0], a_value[39:8], b_value[71:40]
    input  logic [tmm_pkg::OP_W-1:0]          s_tuser,  // op[1:0]
    input  logic                              s_tlast,  // tile_last
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tmm_pkg::M_TDATA_W-1:0]     m_tdata   // c_value[31:0]
);

    import tmm_pkg::*;

    localparam int CELLS      = MAX_TILE * MAX_TILE;
    localparam int AW         = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DIM_W      = $clog2(MAX_TILE + 1);
    localparam int AREA_W     = $clog2(CELLS + 1);
    localparam int CMP_W      = AREA_W + INDEX_W;
    localparam int RESET_EDGE = (DIM_RESET > MAX_TILE) ? MAX_TILE : DIM_RESET;
    localparam int RESET_AREA = RESET_EDGE * RESET_EDGE;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_RDATA,
        S_START,
        S_LOAD,
        S_MAC,
        S_DRAIN,
        S_WRITE
    } state_t;

    // ---------------------------------------------------------------
    // Input field unpacking
    // ---------------------------------------------------------------
    logic [INDEX_W-1:0] in_index;
    logic [DATA_W-1:0]  in_a;
    logic [DATA_W-1:0]  in_b;
    logic               in_xfer;
    logic               in_inside;

    assign in_index = s_tdata[7:0];
    assign in_a     = s_tdata[39:8];
    assign in_b     = s_tdata[71:40];
    assign in_xfer  = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Tile edge register: hold the clamped edge and its square
    // ---------------------------------------------------------------
    logic [DIM_W-1:0]  edge_reg;
    logic [AREA_W-1:0] area_reg;
    logic [DIM_W-1:0]  cfg_edge;
    logic [AREA_W-1:0] cfg_edge_w;

    always_comb begin
        if (cfg_data == '0) begin
            cfg_edge = DIM_W'(1);
        end else if (int'(cfg_data) > MAX_TILE) begin
            cfg_edge = DIM_W'(MAX_TILE);
        end else begin
            cfg_edge = DIM_W'(cfg_data);
        end
    end

    assign cfg_edge_w = AREA_W'(cfg_edge);
    assign cfg_ready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_reg <= DIM_W'(RESET_EDGE);
            area_reg <= AREA_W'(RESET_AREA);
        end else if (cfg_valid && cfg_ready) begin
            edge_reg <= cfg_edge;
            area_reg <= cfg_edge_w * cfg_edge_w;
        end
    end

    assign in_inside = CMP_W'(in_index) < CMP_W'(area_reg);

    // ---------------------------------------------------------------
    // Memories and MAC unit
    // ---------------------------------------------------------------
    logic              tile_wr_en;
    logic              tile_rd_en;
    logic [DATA_W-1:0] a_rdata;
    logic [DATA_W-1:0] b_rdata;
    logic              acc_wr_en;
    logic [AW-1:0]     acc_wr_addr;
    logic [DATA_W-1:0] acc_wr_data;
    logic              acc_rd_en;
    logic [AW-1:0]     acc_rd_addr;
    logic [DATA_W-1:0] acc_rdata;

    tmm_mac_ctrl_t     mac_ctrl;
    logic [DATA_W-1:0] mac_sum;
    logic              mac_pending;

    // sequencer registers
    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [DIM_W-1:0]  r_reg, r_next;
    logic [DIM_W-1:0]  c_reg, c_next;
    logic [DIM_W-1:0]  k_reg, k_next;
    logic [AW-1:0]     a_base_reg, a_base_next;
    logic [AW-1:0]     a_idx_reg, a_idx_next;
    logic [AW-1:0]     b_idx_reg, b_idx_next;
    logic [AW-1:0]     acc_idx_reg, acc_idx_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              inside_reg, inside_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [DIM_W-1:0]  dim_last;
    logic [AW-1:0]     edge_a;
    logic [AW-1:0]     cell_addr;

    tmm_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_a_tile (
        .aclk    (aclk),
        .wr_en   (tile_wr_en),
        .wr_addr (AW'(in_index)),
        .wr_data (in_a),
        .rd_en   (tile_rd_en),
        .rd_addr (a_idx_reg),
        .rd_data (a_rdata)
    );

    tmm_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_b_tile (
        .aclk    (aclk),
        .wr_en   (tile_wr_en),
        .wr_addr (AW'(in_index)),
        .wr_data (in_b),
        .rd_en   (tile_rd_en),
        .rd_addr (b_idx_reg),
        .rd_data (b_rdata)
    );

    tmm_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_acc (
        .aclk    (aclk),
        .wr_en   (acc_wr_en),
        .wr_addr (acc_wr_addr),
        .wr_data (acc_wr_data),
        .rd_en   (acc_rd_en),
        .rd_addr (acc_rd_addr),
        .rd_data (acc_rdata)
    );

    assign mac_ctrl.load   = (state_reg == S_LOAD);
    assign mac_ctrl.mul_en = rd_valid_reg;

    tmm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .init    (acc_rdata),
        .a_data  (a_rdata),
        .b_data  (b_rdata),
        .sum     (mac_sum),
        .pending (mac_pending)
    );

    assign dim_last  = edge_reg - DIM_W'(1);
    assign edge_a    = AW'(edge_reg);
    assign cell_addr = a_base_reg + AW'(c_reg);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        k_next        = k_reg;
        a_base_next   = a_base_reg;
        a_idx_next    = a_idx_reg;
        b_idx_next    = b_idx_reg;
        acc_idx_next  = acc_idx_reg;
        rd_valid_next = 1'b0;
        inside_next   = inside_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;   // drop once taken
        m_tdata_next  = m_tdata_reg;

        tile_wr_en  = 1'b0;
        tile_rd_en  = 1'b0;
        acc_wr_en   = 1'b0;
        acc_wr_addr = acc_idx_reg;
        acc_wr_data = mac_sum;
        acc_rd_en   = 1'b0;
        acc_rd_addr = cell_addr;

        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    case (s_tuser)
                        OP_LOAD: begin
                            tile_wr_en = in_inside;
                            if (s_tlast) begin
                                r_next      = '0;
                                c_next      = '0;
                                a_base_next = '0;
                                state_next  = S_START;
                            end
                        end
                        OP_READ: begin
                            acc_rd_en   = 1'b1;
                            acc_rd_addr = AW'(in_index);
                            inside_next = in_inside;
                            state_next  = S_RDATA;
                        end
                        OP_CLEAR: begin
                            clr_addr_next = '0;
                            state_next    = S_CLEAR;
                        end
                        default: begin
                            // unused op: take the transfer, do nothing
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                acc_wr_en   = 1'b1;
                acc_wr_addr = clr_addr_reg;
                acc_wr_data = '0;
                if (clr_addr_reg == AW'(CELLS - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            S_RDATA: begin
                // hold the read data in the RAM until the output slot frees
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = inside_reg ? acc_rdata : '0;
                    state_next    = S_IDLE;
                end
            end
            S_START: begin
                acc_rd_en    = 1'b1;
                acc_idx_next = cell_addr;
                a_idx_next   = a_base_reg;
                b_idx_next   = AW'(c_reg);
                k_next       = '0;
                state_next   = S_LOAD;
            end
            S_LOAD: begin
                state_next = S_MAC;
            end
            S_MAC: begin
                tile_rd_en    = 1'b1;
                rd_valid_next = 1'b1;
                a_idx_next    = a_idx_reg + AW'(1);
                b_idx_next    = b_idx_reg + edge_a;
                if (k_reg == dim_last) begin
                    k_next     = '0;
                    state_next = S_DRAIN;
                end else begin
                    k_next = k_reg + DIM_W'(1);
                end
            end
            S_DRAIN: begin
                if (!rd_valid_reg && !mac_pending) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                acc_wr_en  = 1'b1;
                state_next = S_START;
                if (c_reg == dim_last) begin
                    c_next      = '0;
                    a_base_next = a_base_reg + edge_a;
                    if (r_reg == dim_last) begin
                        r_next     = '0;
                        state_next = S_IDLE;
                    end else begin
                        r_next = r_reg + DIM_W'(1);
                    end
                end else begin
                    c_next = c_reg + DIM_W'(1);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;     // sweep the accumulators after reset
            clr_addr_reg <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            k_reg        <= '0;
            a_base_reg   <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            k_reg        <= k_next;
            a_base_reg   <= a_base_next;
            rd_valid_reg <= rd_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        a_idx_reg   <= a_idx_next;
        b_idx_reg   <= b_idx_next;
        acc_idx_reg <= acc_idx_next;
        inside_reg  <= inside_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `TMM_ASSERT_SAME(a_writeback_drained, state_reg == S_WRITE, !rd_valid_reg && !mac_pending, "accumulator written back before the MAC pipeline drained")
    `TMM_ASSERT_NEXT(a_clear_sweeps, in_xfer && s_tuser == OP_CLEAR, state_reg == S_CLEAR && clr_addr_reg == '0, "clear transfer did not start the sweep at entry zero")
    `TMM_ASSERT_SAME(a_k_in_tile, state_reg == S_MAC, k_reg < edge_reg, "inner index ran past the tile edge")
    `TMM_ASSERT_NEXT(a_read_delivers, state_reg == S_RDATA && (!m_tvalid_reg || m_tready), m_tvalid_reg && state_reg == S_IDLE, "read result not placed in the output register")

endmodule

>>> tb/tb_tiled_matrix_multiply_top.sv
`timescale 1ns / 1ps

module tb_tiled_matrix_multiply_top;
    import tmm_pkg::*;

    localparam int MAX_EDGE = 16;
    localparam int CELLS = MAX_EDGE * MAX_EDGE;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Track the tile memories and accumulators as the engine should hold them,
    // and queue the c_value that every accepted read must return.
    class accum_scoreboard;
        bit [DIM_CFG_W-1:0] dim_reg;
        bit [DATA_W-1:0] a_mem [CELLS];
        bit [DATA_W-1:0] b_mem [CELLS];
        bit [DATA_W-1:0] acc_mem [CELLS];
        bit loaded [CELLS];
        bit [DATA_W-1:0] expected_c [$];
        int unsigned fail_count;

        function new();
            dim_reg = DIM_CFG_W'(DIM_RESET);
            fail_count = 0;
            foreach (acc_mem[i]) begin
                acc_mem[i] = '0;
                loaded[i] = 1'b0;
            end
        endfunction

        // Clamp the raw register: zero acts as one, too large acts as MAX_EDGE.
        function int unsigned dim_in_use();
            if (dim_reg == 0) return 1;
            if (dim_reg > MAX_EDGE) return MAX_EDGE;
            return dim_reg;
        endfunction

        // True when every cell the next accumulation reads was written.
        function bit tile_complete();
            int unsigned d;
            d = dim_in_use();
            for (int i = 0; i < d * d; i++)
                if (!loaded[i]) return 1'b0;
            return 1'b1;
        endfunction

        function void mac_tiles();
            int unsigned d;
            bit [DATA_W-1:0] sum;
            d = dim_in_use();
            for (int r = 0; r < d; r++)
                for (int c = 0; c < d; c++) begin
                    sum = acc_mem[r * d + c];
                    for (int k = 0; k < d; k++)
                        sum += a_mem[r * d + k] * b_mem[k * d + c];
                    acc_mem[r * d + c] = sum;
                end
        endfunction

        function void note_transfer(logic [OP_W-1:0] op, logic [INDEX_W-1:0] index,
                                    logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                    logic last);
            bit in_tile;
            in_tile = index < dim_in_use() * dim_in_use();
            case (op)
                OP_LOAD: begin
                    if (in_tile) begin
                        a_mem[index] = a;
                        b_mem[index] = b;
                        loaded[index] = 1'b1;
                    end
                    if (last) mac_tiles();
                end
                OP_READ: expected_c.push_back(in_tile ? acc_mem[index] : '0);
                OP_CLEAR: foreach (acc_mem[i]) acc_mem[i] = '0;
                default: ;
            endcase
        endfunction

        function void check_readout(logic [DATA_W-1:0] c);
            bit [DATA_W-1:0] want;
            if (expected_c.size() == 0) begin
                $display("%0t: unexpected c_value, expected none actual %h", $time, c);
                fail_count++;
                return;
            end
            want = expected_c.pop_front();
            if (c !== want) begin
                $display("%0t: c_value mismatch, expected %h actual %h", $time, want, c);
                fail_count++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [DIM_CFG_W-1:0] cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;  // index[7:0], a_value[39:8], b_value[71:40]
    logic [OP_W-1:0]      s_tuser = '0;  // op[1:0]
    logic                 s_tlast = 1'b0;  // tile_last
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;  // c_value[31:0]

    accum_scoreboard board;
    int unsigned send_idle_pct = 13;
    int unsigned recv_idle_pct = 68;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;

    // Tile edges for the random phases; 31 and 0 hit the clamps at both ends.
    bit [DIM_CFG_W-1:0] phase_dims [10] = '{5'd31, 5'd0, 5'd3, 5'd4, 5'd1,
                                            5'd6, 5'd8, 5'd5, 5'd2, 5'd7};

    tiled_matrix_multiply_top #(
        .MAX_TILE(MAX_EDGE)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Stall the result side at random; a new decision every falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Note every accepted input transfer, so reads get their expectation
    // before the engine can answer them.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            board.note_transfer(s_tuser, s_tdata[7:0], s_tdata[39:8], s_tdata[71:40],
                                s_tlast);
    end

    // Check every accepted result transfer against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_readout(m_tdata);
    end

    // Abort a hung run; the limit is many times the slowest correct run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tiled_matrix_multiply_top regression: fail");
            $finish;
        end
    end

    // Favor the sign and all-ones extremes; the rest is random.
    function automatic bit [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Mostly inside the tile, sometimes anywhere in the index range.
    function automatic int unsigned pick_index(int unsigned d);
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 255);
        return $urandom_range(0, d * d - 1);
    endfunction

    // Worst-case busy time: a full accumulation or the clearing sweep, plus slack.
    function automatic int unsigned settle_cycles();
        int unsigned d;
        d = board.dim_in_use();
        return 1 + d * d * (d + 6) + CELLS + 32;
    endfunction

    // Present one item and hold it until the engine takes it.
    task automatic send_item(input logic [OP_W-1:0] op, input int unsigned idx,
                             input bit [DATA_W-1:0] a, input bit [DATA_W-1:0] b,
                             input bit last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {b, a, idx[INDEX_W-1:0]};
        s_tlast = last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    // Drop valid and hold until every expected read has come back.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (board.expected_c.size() != 0) @(negedge aclk);
    endtask

    // Write tile_dim only once the engine has gone quiet.
    task automatic set_tile_dim(input bit [DIM_CFG_W-1:0] value);
        wait_drained();
        repeat (settle_cycles()) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        board.dim_reg = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Unusual items: unused op, stray reads and loads, an occasional clear.
    task automatic send_noise();
        int unsigned d;
        d = board.dim_in_use();
        case ($urandom_range(0, 4))
            0: send_item(OP_UNUSED, $urandom_range(0, 255), pick_word(), pick_word(),
                         bit'($urandom_range(0, 1)));
            1: send_item(OP_READ, $urandom_range(0, 255), pick_word(), pick_word(),
                         bit'($urandom_range(0, 1)));
            2: send_item(OP_LOAD, $urandom_range(0, 255), pick_word(), pick_word(), 1'b0);
            // tile_last is only safe once every cell of the tile holds data
            3: send_item(OP_LOAD, $urandom_range(0, 255), pick_word(), pick_word(),
                         board.tile_complete() ? bit'($urandom_range(0, 1)) : 1'b0);
            default: send_item(OP_CLEAR, pick_index(d), pick_word(), pick_word(),
                               bit'($urandom_range(0, 1)));
        endcase
    endtask

    // Load a whole tile pair in shuffled order, the final load carries tlast,
    // then read back a few accumulators.
    task automatic run_tile_round();
        int unsigned d;
        int unsigned n;
        int unsigned order [CELLS];
        int unsigned j;
        int unsigned swap;
        d = board.dim_in_use();
        n = d * d;
        for (int i = 0; i < n; i++) order[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            swap = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            send_item(OP_LOAD, order[i], pick_word(), pick_word(), i == n - 1);
        end
        repeat ($urandom_range(2, 8))
            send_item(OP_READ, pick_index(d), pick_word(), pick_word(),
                      bit'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0)
            send_item(OP_CLEAR, pick_index(d), pick_word(), pick_word(), 1'b0);
    endtask

    initial begin
        int unsigned phase_start;
        int unsigned rounds;
        board = new();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reads and a clear at the reset edge of 16.
        send_item(OP_READ, 0, '0, '0, 1'b0);
        send_item(OP_READ, 255, '0, '0, 1'b0);
        send_item(OP_UNUSED, 0, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        send_item(OP_CLEAR, 0, '0, '0, 1'b0);

        // Directed: a 2x2 tile of extreme values, then the corner cases.
        set_tile_dim(5'd2);
        send_item(OP_LOAD, 0, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_item(OP_LOAD, 1, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
        send_item(OP_LOAD, 2, 32'hffff_ffff, 32'h8000_0000, 1'b0);
        send_item(OP_LOAD, 3, 32'h0000_0000, 32'h0000_0001, 1'b1);
        for (int i = 0; i < 4; i++) send_item(OP_READ, i, '0, '0, 1'b0);
        // reads outside the tile return zero
        send_item(OP_READ, 4, '0, '0, 1'b0);
        send_item(OP_READ, 255, '0, '0, 1'b1);
        // a load outside the tile writes nothing but still accumulates
        send_item(OP_LOAD, 200, 32'h0000_0001, 32'h0000_0001, 1'b1);
        send_item(OP_READ, 0, '0, '0, 1'b0);
        send_item(OP_READ, 3, '0, '0, 1'b0);
        send_item(OP_UNUSED, 3, 32'h1234_5678, 32'h9abc_def0, 1'b1);
        send_item(OP_CLEAR, 0, '0, '0, 1'b1);
        send_item(OP_READ, 0, '0, '0, 1'b0);
        send_item(OP_LOAD, 3, 32'hffff_ffff, 32'hffff_ffff, 1'b0);

        // Random phases: stall mostly on the result side, then mostly on the
        // input side, then run both sides flat out.
        for (int p = 0; p < 10; p++) begin
            if (p < 4) begin
                send_idle_pct = 13;
                recv_idle_pct = 68;
            end else if (p < 7) begin
                send_idle_pct = 68;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_tile_dim(phase_dims[p]);
            phase_start = items_sent;
            rounds = 0;
            do begin
                run_tile_round();
                // hold the input side once until every read has drained
                if (p == 5 && rounds == 0) wait_drained();
                rounds++;
            end while (items_sent - phase_start < 100);
        end

        // Drain, then give a trailing accumulation time to finish.
        wait_drained();
        repeat (settle_cycles()) @(negedge aclk);
        if (board.fail_count == 0)
            $display("tiled_matrix_multiply_top regression: pass");
        else
            $display("tiled_matrix_multiply_top regression: fail");
        $finish;
    end

endmodule
